// ----- rtl/nearest_centroid_track_id_defines.svh -----
// ----------------------------------------------------------------------------
// Nearest centroid track id: assertion macros
// Shared concurrent assertion forms, compiled out when NO_ASSERTIONS is set.
// ----------------------------------------------------------------------------
`ifndef NEAREST_CENTROID_TRACK_ID_DEFINES_SVH
`define NEAREST_CENTROID_TRACK_ID_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Antecedent holds in a cycle, so the consequent holds in the same cycle.
`define NCT_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("nct same-cycle check failed");
// Antecedent holds in a cycle, so the consequent holds in the next one.
`define NCT_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("nct next-cycle check failed");
`else
`define NCT_ASSERT_SAME(lbl, clk, rstn, ante, cons)
`define NCT_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

// ----- rtl/nct_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Nearest centroid track id: package
// Field widths, the stored entry type and the cell control group.
// ----------------------------------------------------------------------------
package nct_pkg;

  localparam int COORD_W = 16;
  localparam int ID_W    = 16;
  localparam int THR_W   = 16;
  localparam int DIFF_W  = COORD_W + 1;
  localparam int SQ_W    = 2 * COORD_W;
  localparam int DIST_W  = SQ_W + 1;
  localparam int APB_DW  = 32;
  localparam int APB_AW  = 2;

  // Byte address of the match threshold register.
  localparam logic [APB_AW-1:0] ADDR_MATCH_THR = 2'd0;

  // One stored centroid with its track id.
  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic [ID_W-1:0]           id;
  } entry_t;

  // Per-cell control from the sequencer.
  typedef struct packed {
    logic shift;   // rotate the previous-frame entry one cell toward the head
    logic ld_prev; // append the new entry to the previous-frame table
    logic ld_cur;  // record the new entry in the current-frame list
    logic commit;  // end of frame: current entry becomes previous entry
  } cell_ctl_t;

endpackage

// ----- rtl/nct_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Nearest centroid track id: table cell
// Holds one previous-frame entry and one current-frame entry.
// ----------------------------------------------------------------------------
module nct_cell
  import nct_pkg::*;
(
  input  logic      clk,
  input  cell_ctl_t ctl,
  input  entry_t    prev_in,
  input  entry_t    new_entry,
  output entry_t    prev_out
);

  entry_t prev_r;
  entry_t cur_r;

  // Commit, append and rotation never coincide; the order only makes that explicit.
  always_ff @(posedge clk) begin
    priority if (ctl.commit) begin
      prev_r <= cur_r;
    end else if (ctl.ld_prev) begin
      prev_r <= new_entry;
    end else if (ctl.shift) begin
      prev_r <= prev_in;
    end else begin
      prev_r <= prev_r;
    end
    if (ctl.ld_cur) begin
      cur_r <= new_entry;
    end
  end

  assign prev_out = prev_r;

endmodule

// ----- rtl/nct_dist.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Nearest centroid track id: distance unit
// Two-stage pipeline giving the squared distance of the head entry.
// ----------------------------------------------------------------------------
module nct_dist
  import nct_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_vld,
  input  entry_t                    ent,
  input  logic signed [COORD_W-1:0] qx,
  input  logic signed [COORD_W-1:0] qy,
  output logic                      out_vld,
  output logic [DIST_W-1:0]         dist_sq,
  output logic [ID_W-1:0]           dist_id
);

  logic signed [DIFF_W-1:0] dx;
  logic signed [DIFF_W-1:0] dy;
  logic [COORD_W-1:0]       mx_nxt;
  logic [COORD_W-1:0]       my_nxt;

  logic                     s1_vld_r;
  logic [COORD_W-1:0]       s1_mx_r;
  logic [COORD_W-1:0]       s1_my_r;
  logic [ID_W-1:0]          s1_id_r;
  logic                     s2_vld_r;
  logic [SQ_W-1:0]          s2_sqx_r;
  logic [SQ_W-1:0]          s2_sqy_r;
  logic [ID_W-1:0]          s2_id_r;

  // The magnitude of a 17-bit difference of two 16-bit values fits in 16 bits.
  always_comb begin
    dx     = DIFF_W'(ent.x) - DIFF_W'(qx);
    dy     = DIFF_W'(ent.y) - DIFF_W'(qy);
    mx_nxt = dx[DIFF_W-1] ? COORD_W'(-dx) : COORD_W'(dx);
    my_nxt = dy[DIFF_W-1] ? COORD_W'(-dy) : COORD_W'(dy);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= in_vld;
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_mx_r  <= mx_nxt;
    s1_my_r  <= my_nxt;
    s1_id_r  <= ent.id;
    s2_sqx_r <= SQ_W'(s1_mx_r) * SQ_W'(s1_mx_r);
    s2_sqy_r <= SQ_W'(s1_my_r) * SQ_W'(s1_my_r);
    s2_id_r  <= s1_id_r;
  end

  assign out_vld = s2_vld_r;
  assign dist_sq = DIST_W'(s2_sqx_r) + DIST_W'(s2_sqy_r);
  assign dist_id = s2_id_r;

endmodule

// ----- rtl/nearest_centroid_track_id.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Nearest centroid track id: top level
// Assigns a track id to each object centroid by nearest-neighbor search.
// ----------------------------------------------------------------------------
// Usage: an item is taken at a clock edge where start is high and busy is low.
// With in_mode low the item is a centroid; the block searches the previous
// frame's table for the nearest stored centroid (first entry wins on ties),
// reuses its id when it lies within match_threshold, and otherwise hands out
// a fresh id from a wrapping counter and appends the centroid to the table
// if it has room. Every centroid is also recorded in the current-frame
// list if it has room. With in_mode high the item commits the frame: the
// current list replaces the previous table in the same edge, no result
// follows and busy stays low. For a centroid busy stays high while the table
// rotates once past the single distance unit, one entry per cycle, then the
// two pipeline stages drain and a final step decides and writes. The result
// appears on out_valid for exactly one cycle, the cycle in which busy falls;
// a new item may be started in that same cycle. The receiver cannot stall.
// Reset clears the counts, the id counter and sets the threshold to 100;
// the table contents themselves are not cleared and need no clearing pass.
// The threshold is written over the APB port at byte address 0.
// ----------------------------------------------------------------------------
`include "nearest_centroid_track_id_defines.svh"

module nearest_centroid_track_id
  import nct_pkg::*;
#(
  parameter int MAX_TRACKS = 32
) (
  input  logic                      clk,
  input  logic                      rst_n,
  // Input channel
  input  logic                      start,
  output logic                      busy,
  input  logic                      in_mode,
  input  logic signed [COORD_W-1:0] in_centroid_x,
  input  logic signed [COORD_W-1:0] in_centroid_y,
  // Result channel
  output logic                      out_valid,
  output logic [ID_W-1:0]           out_track_id,
  output logic                      out_is_new,
  output logic                      out_table_full,
  // Configuration port
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [APB_AW-1:0]         paddr,
  input  logic [APB_DW-1:0]         pwdata,
  output logic [APB_DW-1:0]         prdata,
  output logic                      pready
);

  localparam int CNT_W  = $clog2(MAX_TRACKS + 1);
  localparam int STEP_W = $clog2(MAX_TRACKS + 3);
  localparam logic [STEP_W-1:0] LAST_ROT = STEP_W'(MAX_TRACKS);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(MAX_TRACKS + 2);
  localparam logic [CNT_W-1:0]  CNT_FULL = CNT_W'(MAX_TRACKS);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_SCAN = 2'b10
  } state_t;

  state_t                    state_r, state_nxt;
  logic [STEP_W-1:0]         step_r, step_nxt;
  logic [CNT_W-1:0]          prev_cnt_r, prev_cnt_nxt;
  logic [CNT_W-1:0]          cur_cnt_r, cur_cnt_nxt;
  logic [ID_W-1:0]           next_id_r, next_id_nxt;
  logic [THR_W-1:0]          thr_r;
  logic [SQ_W-1:0]           thr_sq_r;
  logic signed [COORD_W-1:0] qx_r;
  logic signed [COORD_W-1:0] qy_r;
  logic                      found_r, found_nxt;
  logic [DIST_W-1:0]         best_r, best_nxt;
  logic [ID_W-1:0]           best_id_r, best_id_nxt;

  logic                      out_valid_r;
  logic [ID_W-1:0]           out_id_r;
  logic                      out_new_r;
  logic                      out_full_r;

  logic                      take;
  logic                      take_ctr;
  logic                      take_commit;
  logic                      rotating;
  logic                      issue;
  logic                      finish;
  logic                      fresh;
  logic                      prev_room;
  logic                      cur_room;
  logic [ID_W-1:0]           res_id;
  entry_t                    new_entry;
  entry_t                    prev_q [MAX_TRACKS];
  logic                      d_vld;
  logic [DIST_W-1:0]         d_dist;
  logic [ID_W-1:0]           d_id;
  logic                      cfg_wr;

  // -------------------------------------------------------------------------
  // Configuration port: a write lands when psel, penable and pwrite are high
  // at the threshold address; pready is always high so no access stretches.
  // -------------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr == ADDR_MATCH_THR);
  assign prdata = (paddr == ADDR_MATCH_THR) ? APB_DW'(thr_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= THR_W'(100);
    end else if (cfg_wr) begin
      thr_r <= pwdata[THR_W-1:0];
    end
  end

  // The squared threshold settles in the cycle after a write; a write made late
  // in a scan can miss that scan's decision.
  always_ff @(posedge clk) begin
    thr_sq_r <= SQ_W'(thr_r) * SQ_W'(thr_r);
  end

  // -------------------------------------------------------------------------
  // Sequencer
  // -------------------------------------------------------------------------
  assign busy        = (state_r != ST_IDLE);
  assign take        = start && !busy;
  assign take_ctr    = take && !in_mode;
  assign take_commit = take && in_mode;

  // During the scan the table rotates toward cell 0; at step k the head holds
  // logical entry k, so MAX_TRACKS rotations bring the table back in place.
  assign rotating = (state_r == ST_SCAN) && (step_r < LAST_ROT);
  assign issue    = rotating && (step_r < STEP_W'(prev_cnt_r));
  assign finish   = (state_r == ST_SCAN) && (step_r == LAST_STEP);

  assign fresh     = !found_r || (best_r > DIST_W'(thr_sq_r));
  assign prev_room = (prev_cnt_r != CNT_FULL);
  assign cur_room  = (cur_cnt_r != CNT_FULL);
  assign res_id    = fresh ? next_id_r : best_id_r;

  assign new_entry.x  = qx_r;
  assign new_entry.y  = qy_r;
  assign new_entry.id = res_id;

  always_comb begin
    state_nxt    = state_r;
    step_nxt     = step_r;
    prev_cnt_nxt = prev_cnt_r;
    cur_cnt_nxt  = cur_cnt_r;
    next_id_nxt  = next_id_r;
    found_nxt    = found_r;
    best_nxt     = best_r;
    best_id_nxt  = best_id_r;
    unique case (state_r)
      ST_IDLE: begin
        if (take_ctr) begin
          state_nxt = ST_SCAN;
          step_nxt  = '0;
          found_nxt = 1'b0;
        end else if (take_commit) begin
          prev_cnt_nxt = cur_cnt_r;
          cur_cnt_nxt  = '0;
        end
      end
      ST_SCAN: begin
        step_nxt = step_r + STEP_W'(1);
        // Strict compare keeps the first of equally near entries.
        if (d_vld && (!found_r || (d_dist < best_r))) begin
          found_nxt   = 1'b1;
          best_nxt    = d_dist;
          best_id_nxt = d_id;
        end
        if (finish) begin
          state_nxt = ST_IDLE;
          if (fresh) begin
            next_id_nxt = next_id_r + ID_W'(1);
            if (prev_room) begin
              prev_cnt_nxt = prev_cnt_r + CNT_W'(1);
            end
          end
          if (cur_room) begin
            cur_cnt_nxt = cur_cnt_r + CNT_W'(1);
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= '0;
      prev_cnt_r  <= '0;
      cur_cnt_r   <= '0;
      next_id_r   <= '0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      prev_cnt_r  <= prev_cnt_nxt;
      cur_cnt_r   <= cur_cnt_nxt;
      next_id_r   <= next_id_nxt;
      found_r     <= found_nxt;
      out_valid_r <= finish;
    end
  end

  always_ff @(posedge clk) begin
    best_r    <= best_nxt;
    best_id_r <= best_id_nxt;
    if (take_ctr) begin
      qx_r <= in_centroid_x;
      qy_r <= in_centroid_y;
    end
    if (finish) begin
      out_id_r   <= res_id;
      out_new_r  <= fresh;
      out_full_r <= (fresh && !prev_room) || !cur_room;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_track_id   = out_id_r;
  assign out_is_new     = out_new_r;
  assign out_table_full = out_full_r;

  // -------------------------------------------------------------------------
  // Row of table cells, closed into a ring for the rotation.
  // -------------------------------------------------------------------------
  for (genvar i = 0; i < MAX_TRACKS; i++) begin : g_cell
    cell_ctl_t ctl;

    assign ctl.shift   = rotating;
    assign ctl.ld_prev = finish && fresh && (prev_cnt_r == CNT_W'(i));
    assign ctl.ld_cur  = finish && (cur_cnt_r == CNT_W'(i));
    assign ctl.commit  = take_commit;

    nct_cell u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .prev_in   (prev_q[(i + 1) % MAX_TRACKS]),
      .new_entry (new_entry),
      .prev_out  (prev_q[i])
    );
  end

  nct_dist u_dist (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (issue),
    .ent     (prev_q[0]),
    .qx      (qx_r),
    .qy      (qy_r),
    .out_vld (d_vld),
    .dist_sq (d_dist),
    .dist_id (d_id)
  );

  // -------------------------------------------------------------------------
  // Assertions
  // -------------------------------------------------------------------------
  // A result is delivered only right after a scan, with the block idle again.
  `NCT_ASSERT_SAME(a_out_after_scan, clk, rst_n, out_valid, !busy && $past(busy))
  // A centroid transfer always starts a scan.
  `NCT_ASSERT_NEXT(a_ctr_starts_scan, clk, rst_n, take_ctr, busy)
  // Neither count ever passes the table size.
  `NCT_ASSERT_SAME(a_counts_bounded, clk, rst_n, 1'b1,
                   (prev_cnt_r <= CNT_FULL) && (cur_cnt_r <= CNT_FULL))
  // The distance pipeline is empty whenever the block is idle.
  `NCT_ASSERT_SAME(a_pipe_idle, clk, rst_n, !busy, !d_vld)

endmodule
